@@ src/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/chlg_pkg.sv @@
package chlg_pkg;

    // field widths
    localparam int AVG_W   = 15;
    localparam int DLY_W   = 16;
    localparam int BP1_W   = 14;
    localparam int BP2_W   = 18;
    localparam int CDATA_W = 16;
    localparam int CIDX_W  = 3;

    localparam logic [AVG_W-1:0] LOAD_SCALE = 15'd100;
    localparam logic [BP2_W-1:0] DELAY_MAX  = 18'd65535;

    // decision codes
    localparam logic [1:0] DEC_HOLD = 2'd0;
    localparam logic [1:0] DEC_ALL  = 2'd1;
    localparam logic [1:0] DEC_OFF  = 2'd2;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_MIN_ONLINE  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_CPU_COUNT   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_ENABLE_PER  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_DISABLE_PER = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_BASE_PERIOD = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_OFF_DELAY   = 3'd5;

    typedef struct packed {
        logic [7:0] run_count;
        logic [3:0] online_now;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       decision;
        logic [AVG_W-1:0] avg_load;
        logic [DLY_W-1:0] delay_ms;
        logic [2:0]       target_core;
    } t_out_word;

    typedef struct packed {
        logic [3:0]  min_online;
        logic [3:0]  cpu_count;
        logic [9:0]  enable_per_cpu;
        logic [9:0]  disable_per_cpu;
        logic [9:0]  base_period;
        logic [15:0] offline_delay;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic upd;
        logic mul;
        logic qw;
        logic avg;
        logic dec;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_blocked;
        logic out_full;
    } t_sts;

endpackage

@@ src/chlg_ctrl.sv @@
module chlg_ctrl import chlg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_MUL,
        S_QW,
        S_AVG,
        S_DEC
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_UPD;
            end
            S_UPD:  n_state = S_MUL;
            S_MUL:  n_state = S_QW;
            S_QW:   n_state = S_AVG;
            S_AVG:  n_state = S_DEC;
            S_DEC: begin
                if (!i_sts.out_blocked) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // command decode
    always_comb begin
        o_cmd      = '0;
        o_cmd.take = (r_state == S_IDLE) && i_in_valid;
        o_cmd.upd  = (r_state == S_UPD);
        o_cmd.mul  = (r_state == S_MUL);
        o_cmd.qw   = (r_state == S_QW);
        o_cmd.avg  = (r_state == S_AVG);
        o_cmd.dec  = (r_state == S_DEC) && !i_sts.out_blocked;
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ src/chlg_dp.sv @@
module chlg_dp import chlg_pkg::*; #(
    parameter int WINDOW   = 20,
    parameter int MAX_CPUS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  t_in_word  i_in_word,
    input  t_cfg      i_cfg,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    localparam int SUM_W = $clog2(WINDOW * 25500 + 1);
    localparam int POS_W = $clog2(WINDOW);
    localparam int CNT_W = ($clog2(MAX_CPUS + 1) > 4) ? $clog2(MAX_CPUS + 1) : 4;
    localparam int CMP_W = 11 + CNT_W;

    localparam logic [SUM_W-1:0] RECIP = SUM_W'((2 ** SUM_W) / WINDOW);
    localparam logic [SUM_W-1:0] WIN_C = SUM_W'(WINDOW);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_CPUS);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

    // load ring and its valid bits
    logic [AVG_W-1:0]  r_ring [WINDOW];
    logic [WINDOW-1:0] r_ring_vld;
    logic [POS_W-1:0]  r_pos;
    logic [AVG_W-1:0]  r_rd_data;
    logic              r_rd_vld;

    logic [SUM_W-1:0]   r_sum;
    logic [AVG_W-1:0]   r_running;
    logic [3:0]         r_online;
    logic [2*SUM_W-1:0] r_prod;
    logic [AVG_W-1:0]   r_q;
    logic [SUM_W-1:0]   r_qw;
    logic [AVG_W-1:0]   r_avg;
    logic [CNT_W-1:0]   r_cores;
    logic [CNT_W-1:0]   r_min;
    logic [CMP_W-1:0]   r_en_thr;
    logic [CMP_W-1:0]   r_dis_thr;
    logic [BP1_W-1:0]   r_bp1;
    logic [BP2_W-1:0]   r_bp2;
    logic               r_out_vld;
    t_out_word          r_out;

    logic [AVG_W-1:0] w_old;
    logic [SUM_W-1:0] w_q;
    logic [SUM_W-1:0] w_rem;
    logic [CNT_W-1:0] w_cpu;
    logic [CNT_W-1:0] w_mn;
    logic [CNT_W-1:0] w_cores;
    logic [CNT_W-1:0] w_min;
    logic [CNT_W-1:0] w_on;
    logic [CMP_W-1:0] w_avg;
    logic [3:0]       w_tgt;
    logic             w_all;
    logic             w_off;
    t_out_word        w_out;

    // ring memory, read on accept and written on update
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_rd_data <= r_ring[r_pos];
        end
        if (i_cmd.upd) begin
            r_ring[r_pos] <= r_running;
        end
    end

    // ring control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
            r_pos      <= '0;
            r_sum      <= '0;
        end else if (i_cmd.upd) begin
            r_ring_vld[r_pos] <= 1'b1;
            r_pos             <= (r_pos == POS_LAST) ? '0 : r_pos + POS_W'(1);
            r_sum             <= r_sum - SUM_W'(w_old) + SUM_W'(r_running);
        end
    end

    assign w_old = r_rd_vld ? r_rd_data : '0;

    // clamped core count and minimum
    always_comb begin
        w_cpu   = CNT_W'(i_cfg.cpu_count);
        w_cores = (w_cpu == '0) ? ONE_C : ((w_cpu > MAX_C) ? MAX_C : w_cpu);
        w_mn    = CNT_W'(i_cfg.min_online);
        w_min   = (w_mn > w_cores) ? w_cores : w_mn;
        if (w_min == '0) w_min = ONE_C;
    end

    assign w_q   = r_prod[2*SUM_W-1:SUM_W];
    assign w_rem = r_sum - r_qw;

    // sequenced datapath steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_running <= i_in_word.run_count * LOAD_SCALE;
            r_online  <= i_in_word.online_now;
            r_rd_vld  <= r_ring_vld[r_pos];
        end
        if (i_cmd.upd) begin
            r_cores   <= w_cores;
            r_min     <= w_min;
            r_en_thr  <= CMP_W'(i_cfg.enable_per_cpu) * CMP_W'(w_cores);
            r_dis_thr <= CMP_W'(i_cfg.disable_per_cpu) * CMP_W'(r_online);
            r_bp1     <= BP1_W'(i_cfg.base_period) * BP1_W'(r_online);
        end
        if (i_cmd.mul) begin
            r_prod <= {{SUM_W{1'b0}}, r_sum} * {{SUM_W{1'b0}}, RECIP};
            r_bp2  <= BP2_W'(r_bp1) * BP2_W'(r_online);
        end
        // reciprocal quotient may be one low
        if (i_cmd.qw) begin
            r_q  <= AVG_W'(w_q);
            r_qw <= w_q * WIN_C;
        end
        if (i_cmd.avg) begin
            r_avg <= r_q + AVG_W'(w_rem >= WIN_C);
        end
        if (i_cmd.dec) begin
            r_out <= w_out;
        end
    end

    // decision
    always_comb begin
        w_on  = CNT_W'(r_online);
        w_avg = CMP_W'(r_avg);
        w_all = ((w_avg >= r_en_thr) && (w_on < r_cores)) || (w_on < r_min);
        w_off = (w_avg <= r_dis_thr) && (w_on > r_min);
        w_tgt = r_online - 4'd1;
        w_out          = '0;
        w_out.avg_load = r_avg;
        if (w_all) begin
            w_out.decision = DEC_ALL;
        end else if (w_off) begin
            w_out.decision    = DEC_OFF;
            w_out.delay_ms    = i_cfg.offline_delay;
            w_out.target_core = (w_tgt > 4'd7) ? 3'd7 : w_tgt[2:0];
        end else begin
            w_out.decision = DEC_HOLD;
            w_out.delay_ms = (r_bp2 > DELAY_MAX) ? DELAY_MAX[DLY_W-1:0] : r_bp2[DLY_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.dec) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_out_word        = r_out;
    assign o_sts.out_full    = r_out_vld;
    assign o_sts.out_blocked = r_out_vld && i_out_stall;

endmodule

@@ src/core_hotplug_load_governor.sv @@
// channel  dir  handshake                   payload
// in       in   i_in_valid / o_in_stall     t_in_word
// out      out  o_out_valid / i_out_stall   t_out_word
// cfg      in   i_cfg_we                    i_cfg_idx, i_cfg_data
//
// result registered at the end of the controller sequence: ring read, sum update,
// reciprocal multiply, quotient check, average fix, decide. no new word is taken until
// the decide step is done; a new word is taken the cycle after the result is loaded.
// a stalled result holds the decide step until the output register frees.
// synchronous reset clears the ring at once through per-entry valid bits, no clear pass.
`include "assert_macros.svh"

module core_hotplug_load_governor import chlg_pkg::*; #(
    parameter int WINDOW   = 20,
    parameter int MAX_CPUS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_word           i_in_word,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_word          o_out_word,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_idx,
    input  logic [CDATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_online      <= 4'd1;
            r_cfg.cpu_count       <= 4'd4;
            r_cfg.enable_per_cpu  <= 10'd100;
            r_cfg.disable_per_cpu <= 10'd55;
            r_cfg.base_period     <= 10'd10;
            r_cfg.offline_delay   <= 16'd2000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_ONLINE:  r_cfg.min_online      <= i_cfg_data[3:0];
                CFG_CPU_COUNT:   r_cfg.cpu_count       <= i_cfg_data[3:0];
                CFG_ENABLE_PER:  r_cfg.enable_per_cpu  <= i_cfg_data[9:0];
                CFG_DISABLE_PER: r_cfg.disable_per_cpu <= i_cfg_data[9:0];
                CFG_BASE_PERIOD: r_cfg.base_period     <= i_cfg_data[9:0];
                CFG_OFF_DELAY:   r_cfg.offline_delay   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer
    chlg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // ring, average and decision datapath
    chlg_dp #(
        .WINDOW   (WINDOW),
        .MAX_CPUS (MAX_CPUS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_word   (i_in_word),
        .i_cfg       (r_cfg),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    // checks
    `ASSERT_NEXT(a_busy_after_take, i_in_valid && !o_in_stall, o_in_stall)
    `ASSERT_IMPL(a_one_step, 1'b1, $onehot0(w_cmd))
    `ASSERT_IMPL(a_no_overwrite, w_cmd.dec, !(o_out_valid && i_out_stall))
    `ASSERT_NEXT(a_dec_shows, w_cmd.dec, o_out_valid && w_sts.out_full)
    `ASSERT_IMPL(a_dec_code, o_out_valid, o_out_word.decision <= DEC_OFF)

endmodule

@@ test/core_hotplug_load_governor_tb.sv @@
`timescale 1ns / 1ps

module core_hotplug_load_governor_tb import chlg_pkg::*; ;

    localparam int RING_LEN    = 20;
    localparam int CORES_MAX   = 8;
    localparam int unsigned SCALE   = 100;
    localparam int unsigned DLY_CAP = 65535;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_LEN    = 300;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 165;
    localparam int SHOW_MAX    = 10;

    // indexes with no register behind them
    localparam logic [CIDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    t_in_word           i_in_word = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_word          o_out_word;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CIDX_W-1:0]  i_cfg_idx = '0;
    logic [CDATA_W-1:0] i_cfg_data = '0;

    core_hotplug_load_governor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // governor state as the predictor sees it
    logic [AVG_W-1:0] load_hist [RING_LEN];
    int unsigned      hist_pos;
    int unsigned      hist_sum;
    t_cfg             gov_cfg;

    t_in_word  sample_q [$];
    t_out_word verdict_q [$];
    t_out_word want_word;
    int        n_queued = 0;
    int        n_accepted = 0;
    int        n_checked = 0;
    int        n_mismatch = 0;
    int        cycle_no = 0;
    logic      in_fire = 1'b0;
    logic      out_fire = 1'b0;

    // sender and receiver pacing
    int   send_gap = 0;
    logic send_busy = 1'b0;
    logic send_calm = 1'b0;
    int   rx_gap = 0;
    logic rx_calm = 1'b0;
    int   hold_cnt = 0;
    logic hold_done = 1'b0;

    function automatic void gov_reset();
        for (int k = 0; k < RING_LEN; k++) load_hist[k] = '0;
        hist_pos = 0;
        hist_sum = 0;
        gov_cfg.min_online      = 4'd1;
        gov_cfg.cpu_count       = 4'd4;
        gov_cfg.enable_per_cpu  = 10'd100;
        gov_cfg.disable_per_cpu = 10'd55;
        gov_cfg.base_period     = 10'd10;
        gov_cfg.offline_delay   = 16'd2000;
    endfunction

    // push one sample through the window and pick the hotplug action
    function automatic t_out_word gov_predict(input t_in_word w);
        int unsigned scaled, online, cores, floor_on, avg, dly;
        t_out_word   r;
        scaled = w.run_count * SCALE;
        online = w.online_now;
        hist_sum = hist_sum - load_hist[hist_pos] + scaled;
        load_hist[hist_pos] = AVG_W'(scaled);
        hist_pos = (hist_pos + 1 == RING_LEN) ? 0 : hist_pos + 1;
        avg = hist_sum / RING_LEN;

        // clamp core count, then the minimum against it
        cores = gov_cfg.cpu_count;
        if (cores < 1) cores = 1;
        if (cores > CORES_MAX) cores = CORES_MAX;
        floor_on = gov_cfg.min_online;
        if (floor_on > cores) floor_on = cores;
        if (floor_on < 1) floor_on = 1;

        r = '0;
        r.avg_load = AVG_W'(avg);
        if ((avg >= gov_cfg.enable_per_cpu * cores && online < cores) || online < floor_on) begin
            r.decision = DEC_ALL;
        end else if (avg <= gov_cfg.disable_per_cpu * online && online > floor_on) begin
            r.decision    = DEC_OFF;
            r.delay_ms    = gov_cfg.offline_delay;
            r.target_core = (online - 1 > 7) ? 3'd7 : 3'(online - 1);
        end else begin
            dly = gov_cfg.base_period * online * online;
            if (dly > DLY_CAP) dly = DLY_CAP;
            r.decision = DEC_HOLD;
            r.delay_ms = DLY_W'(dly);
        end
        return r;
    endfunction

    // mostly a typical value, sometimes zero or the top of the field
    function automatic int unsigned pick_span(int unsigned lo, int unsigned hi,
                                              int unsigned top);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return top;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    task automatic offer_sample(input logic [7:0] run, input logic [3:0] online);
        t_in_word w;
        w.run_count  = run;
        w.online_now = online;
        sample_q.push_back(w);
        n_queued++;
    endtask

    task automatic put_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    // every register, plus writes to the spare indexes; junk above every field but the offline delay
    task automatic load_regs(input t_cfg c);
        put_reg(CFG_MIN_ONLINE, {12'($urandom), c.min_online});
        put_reg(CFG_CPU_COUNT, {12'($urandom), c.cpu_count});
        put_reg(CFG_ENABLE_PER, {6'($urandom), c.enable_per_cpu});
        put_reg(CFG_DISABLE_PER, {6'($urandom), c.disable_per_cpu});
        put_reg(CFG_SPARE_LO, 16'($urandom));
        put_reg(CFG_BASE_PERIOD, {6'($urandom), c.base_period});
        put_reg(CFG_OFF_DELAY, c.offline_delay);
        put_reg(CFG_SPARE_HI, 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (n_accepted != n_queued || verdict_q.size() != 0);
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (in_fire) send_busy = 1'b0;
        if (!send_busy && sample_q.size() > 0) begin
            if (send_gap > 0) begin
                send_gap--;
            end else begin
                i_in_word <= sample_q.pop_front();
                send_busy = 1'b1;
                if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, 16);
            end
        end
        i_in_valid <= send_busy;
    end

    // output stall per word
    always @(negedge i_clk) begin
        if (out_fire) begin
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
            rx_gap = rx_calm ? 0 : $urandom_range(0, 16);
        end else if (rx_gap > 0) begin
            rx_gap--;
        end
        i_out_stall <= (rx_gap > 0) || (hold_cnt > 0);
    end

    // one long output hold so the block backs up into its input
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // monitor: register writes, accepted samples, results
    always @(posedge i_clk) begin
        cycle_no++;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_no,
                     verdict_q.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            in_fire  <= i_rst_n && i_in_valid && !o_in_stall;
            out_fire <= i_rst_n && o_out_valid && !i_out_stall;
            if (!i_rst_n) begin
                gov_reset();
            end else begin
                if (i_cfg_we) begin
                    case (i_cfg_idx)
                        CFG_MIN_ONLINE:  gov_cfg.min_online = i_cfg_data[3:0];
                        CFG_CPU_COUNT:   gov_cfg.cpu_count = i_cfg_data[3:0];
                        CFG_ENABLE_PER:  gov_cfg.enable_per_cpu = i_cfg_data[9:0];
                        CFG_DISABLE_PER: gov_cfg.disable_per_cpu = i_cfg_data[9:0];
                        CFG_BASE_PERIOD: gov_cfg.base_period = i_cfg_data[9:0];
                        CFG_OFF_DELAY:   gov_cfg.offline_delay = i_cfg_data;
                        default: ;
                    endcase
                end
                if (i_in_valid && !o_in_stall) begin
                    verdict_q.push_back(gov_predict(i_in_word));
                    n_accepted++;
                end
                if (o_out_valid && !i_out_stall) begin
                    if (verdict_q.size() == 0) begin
                        n_mismatch++;
                        if (n_mismatch <= SHOW_MAX)
                            $display("unexpected result dec=%0d avg=%0d dly=%0d core=%0d",
                                     o_out_word.decision, o_out_word.avg_load,
                                     o_out_word.delay_ms, o_out_word.target_core);
                    end else begin
                        want_word = verdict_q.pop_front();
                        if (o_out_word.decision !== want_word.decision ||
                            o_out_word.avg_load !== want_word.avg_load ||
                            o_out_word.delay_ms !== want_word.delay_ms ||
                            o_out_word.target_core !== want_word.target_core) begin
                            n_mismatch++;
                            if (n_mismatch <= SHOW_MAX) begin
                                $write("mismatch on result %0d: want dec=%0d avg=%0d ",
                                       n_checked, want_word.decision,
                                       want_word.avg_load);
                                $write("dly=%0d core=%0d, ", want_word.delay_ms,
                                       want_word.target_core);
                                $display("got dec=%0d avg=%0d dly=%0d core=%0d",
                                         o_out_word.decision, o_out_word.avg_load,
                                         o_out_word.delay_ms, o_out_word.target_core);
                            end
                        end
                    end
                    n_checked++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_cfg        c;
        int unsigned lvl;
        int unsigned online;

        lvl = 255;
        gov_reset();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: no core online, saturated target, all three actions
        offer_sample(8'd0, 4'd0);
        offer_sample(8'd0, 4'd15);
        offer_sample(8'd255, 4'd1);
        offer_sample(8'd255, 4'd4);
        offer_sample(8'd255, 4'd8);
        offer_sample(8'd0, 4'd2);
        offer_sample(8'd128, 4'd3);
        offer_sample(8'd255, 4'd0);
        offer_sample(8'd1, 4'd5);
        offer_sample(8'd200, 4'd9);
        wait_drained();

        // minimum above core count, core count of zero, every other field at its top
        c = '{4'd15, 4'd0, 10'd1023, 10'd1023, 10'd1023, 16'd65535};
        load_regs(c);
        offer_sample(8'd255, 4'd15);
        offer_sample(8'd0, 4'd1);
        offer_sample(8'd0, 4'd2);
        offer_sample(8'd255, 4'd3);
        offer_sample(8'd17, 4'd8);
        wait_drained();

        // minimum of zero, core count above the limit, zero thresholds and periods
        c = '{4'd0, 4'd15, 10'd0, 10'd0, 10'd0, 16'd0};
        load_regs(c);
        offer_sample(8'd255, 4'd3);
        offer_sample(8'd255, 4'd8);
        offer_sample(8'd0, 4'd8);
        offer_sample(8'd85, 4'd12);
        wait_drained();

        // hold delay saturating, below-minimum online
        c = '{4'd2, 4'd8, 10'd1, 10'd0, 10'd1023, 16'd12345};
        load_regs(c);
        offer_sample(8'd255, 4'd15);
        offer_sample(8'd170, 4'd1);
        offer_sample(8'd0, 4'd2);
        offer_sample(8'd255, 4'd7);
        wait_drained();

        // random settings per phase, load level moving in steps
        for (int p = 0; p < PHASES; p++) begin
            c.min_online      = 4'(pick_span(1, 4, 15));
            c.cpu_count       = 4'(pick_span(1, 8, 15));
            c.enable_per_cpu  = 10'(pick_span(20, 400, 1023));
            c.disable_per_cpu = 10'(pick_span(10, 300, 1023));
            c.base_period     = 10'(pick_span(1, 200, 1023));
            c.offline_delay   = 16'(pick_span(0, 5000, 65535));
            load_regs(c);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 25 == 0) begin
                    case ($urandom_range(0, 3))
                        0: lvl = 3;
                        1: lvl = 20;
                        2: lvl = 80;
                        default: lvl = 255;
                    endcase
                end
                case ($urandom_range(0, 19))
                    0: online = 0;
                    1, 2: online = $urandom_range(9, 15);
                    default: online = $urandom_range(1, 8);
                endcase
                offer_sample(8'($urandom_range(0, lvl)), 4'(online));
            end
            wait_drained();
        end

        // let any stray result show up
        repeat (20) @(negedge i_clk);
        n_mismatch += verdict_q.size();
        if (n_mismatch == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
